[hdl/isort_pkg.sv]
`timescale 1ns / 1ps

package isort_pkg;

   localparam int DEPTH = 16;

   typedef struct packed {
      logic signed [31:0] value;
      logic               final_item;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               last_result;
      logic               overflowed;
   } rsp_type;

   // Broadcast to every cell of the row.
   typedef struct packed {
      logic               insert;
      logic               shift_out;
      logic signed [31:0] value;
   } cell_ctl_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      logic               occupied;
      logic               greater;
      logic signed [31:0] value;
   } cell_link_type;

   typedef enum logic {
      ST_COLLECT,
      ST_DRAIN
   } state_type;

endpackage

[hdl/isort_cell.sv]
`timescale 1ns / 1ps

module isort_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  isort_pkg::cell_ctl_type  ctl,
   input  isort_pkg::cell_link_type left,
   input  isort_pkg::cell_link_type right,
   output isort_pkg::cell_link_type link
);
   import isort_pkg::*;

   logic signed [31:0] val_ff, val_in;
   logic               occ_ff, occ_in;
   logic               greater;

   // Strictly greater keeps equal values ahead of the new one (stable).
   assign greater = occ_ff && (val_ff > ctl.value);

   always_comb begin
      val_in = val_ff;
      occ_in = occ_ff;
      if (ctl.shift_out) begin
         val_in = right.value;
         occ_in = right.occupied;
      end else if (ctl.insert) begin
         if (left.greater) begin
            val_in = left.value;
            occ_in = 1'b1;
         end else if ((greater || !occ_ff) && left.occupied) begin
            val_in = ctl.value;
            occ_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
      val_ff <= val_in;
   end

   assign link.occupied = occ_ff;
   assign link.greater  = greater;
   assign link.value    = val_ff;

endmodule

[hdl/insertion_sorter_unit.sv]
`timescale 1ns / 1ps

// channel | ports                      | beat
// --------+----------------------------+--------------------------------------
// input   | start, busy, req_beat      | taken when start is high, busy low
// result  | rsp_strobe, rsp_beat       | one cycle per beat, no back-pressure
//
// A value is registered into the cell row when taken; back-to-back inputs
// are taken while collecting. A final item starts the drain: one result per
// held value, one per cycle, with busy high for the whole drain.
// Reset empties the row and clears the overflow flag. Results cannot be
// stalled by the receiver.
module insertion_sorter_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  isort_pkg::req_type req_beat,
   output logic               rsp_strobe,
   output isort_pkg::rsp_type rsp_beat
);
   import isort_pkg::*;

   state_type     state_ff, state_in;
   logic          ovf_ff, ovf_in;
   logic          accept, full, last_out;
   cell_ctl_type  ctl;
   cell_link_type links [DEPTH];

   localparam cell_link_type EDGE_LEFT  = '{occupied: 1'b1, greater: 1'b0, value: '0};
   localparam cell_link_type EDGE_RIGHT = '{occupied: 1'b0, greater: 1'b0, value: '0};

   assign accept   = start && !busy;
   assign full     = links[DEPTH-1].occupied;
   assign last_out = !links[1].occupied;

   assign ctl.insert    = accept && !full;
   assign ctl.shift_out = (state_ff == ST_DRAIN);
   assign ctl.value     = req_beat.value;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      isort_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .left  ((i == 0) ? EDGE_LEFT : links[(i == 0) ? 0 : i-1]),
         .right ((i == DEPTH-1) ? EDGE_RIGHT : links[(i == DEPTH-1) ? i : i+1]),
         .link  (links[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      ovf_in   = ovf_ff;
      busy     = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            if (accept && full) begin
               ovf_in = 1'b1;
            end
            if (accept && req_beat.final_item) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            busy = 1'b1;
            if (last_out) begin
               state_in = ST_COLLECT;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign rsp_strobe            = (state_ff == ST_DRAIN);
   assign rsp_beat.sorted_value = links[0].value;
   assign rsp_beat.last_result  = last_out;
   assign rsp_beat.overflowed   = ovf_ff;

endmodule
